// File: hdl/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
package i2cms_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CNT_W     = 4;
  localparam int TMO_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_CLOCK_COUNT = 1'b1;

  localparam logic [TMO_W-1:0] ACK_TIMEOUT_RST       = 3'd5;
  localparam logic [CNT_W-1:0] RESET_CLOCK_COUNT_RST = 4'd9;

  typedef enum logic [2:0] {
    K_START     = 3'd0,
    K_STOP      = 3'd1,
    K_SEND      = 3'd2,
    K_WAIT_ACK  = 3'd3,
    K_RECV      = 3'd4,
    K_ACK       = 3'd5,
    K_NACK      = 3'd6,
    K_BUS_RESET = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_FOURTH = 2'd3
  } phase_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_released;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_data;
    logic                 ack_failed;
  } result_t;

endpackage

// File: hdl/i2cms_if.sv
// valid/ready channel interfaces for command ticks and pin results
interface i2cms_in_if;
  import i2cms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd_valid;
  logic [2:0]           kind;
  logic [BYTE_BITS-1:0] tx_byte;
  logic                 sda_in;

  modport source (output valid, cmd_valid, kind, tx_byte, sda_in, input ready);
  modport sink   (input valid, cmd_valid, kind, tx_byte, sda_in, output ready);
endinterface

interface i2cms_out_if;
  import i2cms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 scl_level;
  logic                 sda_level;
  logic                 sda_released;
  logic                 busy_res;
  logic                 done_res;
  logic [BYTE_BITS-1:0] rx_data;
  logic                 ack_failed;

  modport source (output valid, scl_level, sda_level, sda_released, busy_res, done_res,
                  rx_data, ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_released, busy_res, done_res,
                  rx_data, ack_failed, output ready);
endinterface

// File: hdl/i2c_master_bit_sequencer.sv
// i2c master pin sequencer: one quarter-bit tick in, one pin snapshot out
//
//  channel   dir   payload                                         handshake
//  tick      in    cmd_valid, kind, tx_byte, sda_in                valid/ready
//  pins      out   scl, sda, release, busy, done, rx_data, fail    valid/ready
//  cfg       in    cfg_index, cfg_data                             cfg_we only
//
// one tick per clock while tick ready is high; each accepted transaction advances
// the sequencer one phase and its pin snapshot is registered in the output stage
// a two-entry output stage (result register plus skid) keeps ticks flowing
// while the sink stalls; tick ready drops only when both entries are full
// rst is synchronous: pins idle high, sda driven, sequencer idle, config defaults
module i2c_master_bit_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CFG_W-1:0]       cfg_data,
  i2cms_in_if.sink                          tick,
  i2cms_out_if.source                       pins
);
  import i2cms_pkg::*;

  // configuration
  logic [TMO_W-1:0] ack_timeout;
  logic [CNT_W-1:0] reset_clock_count;

  // sequencer state
  kind_t                active_command, active_command_next;
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bit_counter, bit_counter_next;
  logic [BYTE_BITS-1:0] shift_register, shift_register_next;
  logic [TMO_W-1:0]     timeout_counter, timeout_counter_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic                 release_reg, release_reg_next;
  logic                 busy_reg, busy_reg_next;
  logic                 fail_reg, fail_reg_next;
  logic                 done_next;

  // output stage
  result_t result_new;
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;

  logic accept, out_fire;
  logic [CNT_W-1:0] lim;

  assign tick.ready = !skid_valid;
  assign accept     = tick.valid && tick.ready;
  assign out_fire   = out_valid && pins.ready;

  // zero limits behave as one
  assign lim = (reset_clock_count == '0) ? CNT_W'(1) : reset_clock_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout       <= ACK_TIMEOUT_RST;
      reset_clock_count <= RESET_CLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACK_TIMEOUT:       ack_timeout       <= cfg_data[TMO_W-1:0];
        CFG_RESET_CLOCK_COUNT: reset_clock_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // one phase of the sequence per tick
  always_comb begin
    active_command_next  = active_command;
    phase_next           = phase;
    bit_counter_next     = bit_counter;
    shift_register_next  = shift_register;
    timeout_counter_next = timeout_counter;
    scl_reg_next         = scl_reg;
    sda_reg_next         = sda_reg;
    release_reg_next     = release_reg;
    busy_reg_next        = busy_reg;
    fail_reg_next        = fail_reg;
    done_next            = 1'b0;

    // new command only when idle; ignored while busy
    if (!busy_reg && tick.cmd_valid) begin
      active_command_next = kind_t'(tick.kind);
      phase_next          = PH_FIRST;
      bit_counter_next    = '0;
      busy_reg_next       = 1'b1;
      case (kind_t'(tick.kind))
        K_SEND: shift_register_next = tick.tx_byte;
        K_RECV: shift_register_next = '0;
        K_WAIT_ACK: begin
          timeout_counter_next = (ack_timeout == '0) ? TMO_W'(1) : ack_timeout;
          fail_reg_next        = 1'b0;
        end
        default: ;
      endcase
    end

    if (busy_reg_next) begin
      case (active_command_next)
        K_START: begin
          case (phase_next)
            PH_FIRST: begin
              sda_reg_next = 1'b1; scl_reg_next = 1'b1; release_reg_next = 1'b0;
              phase_next = PH_SECOND;
            end
            PH_SECOND: begin
              sda_reg_next = 1'b0; phase_next = PH_THIRD;
            end
            default: begin
              scl_reg_next = 1'b0;
              busy_reg_next = 1'b0; done_next = 1'b1;
              phase_next = PH_FIRST; bit_counter_next = '0;
            end
          endcase
        end
        K_STOP: begin
          case (phase_next)
            PH_FIRST: begin
              scl_reg_next = 1'b0; sda_reg_next = 1'b0; release_reg_next = 1'b0;
              phase_next = PH_SECOND;
            end
            PH_SECOND: begin
              scl_reg_next = 1'b1; phase_next = PH_THIRD;
            end
            default: begin
              sda_reg_next = 1'b1;
              busy_reg_next = 1'b0; done_next = 1'b1;
              phase_next = PH_FIRST; bit_counter_next = '0;
            end
          endcase
        end
        K_SEND: begin
          case (phase_next)
            PH_FIRST: begin
              if (bit_counter_next >= CNT_W'(BYTE_BITS)) begin
                busy_reg_next = 1'b0; done_next = 1'b1;
                phase_next = PH_FIRST; bit_counter_next = '0;
              end else begin
                scl_reg_next = 1'b0; release_reg_next = 1'b0;
                phase_next = PH_SECOND;
              end
            end
            PH_SECOND: begin
              sda_reg_next        = shift_register_next[BYTE_BITS-1];
              shift_register_next = {shift_register_next[BYTE_BITS-2:0], 1'b0};
              phase_next          = PH_THIRD;
            end
            PH_THIRD: begin
              scl_reg_next     = 1'b1;
              bit_counter_next = bit_counter_next + CNT_W'(1);
              phase_next = (bit_counter_next >= CNT_W'(BYTE_BITS)) ? PH_FOURTH : PH_FIRST;
            end
            default: begin
              scl_reg_next = 1'b0; phase_next = PH_FIRST;
            end
          endcase
        end
        K_WAIT_ACK: begin
          case (phase_next)
            PH_FIRST: begin
              release_reg_next = 1'b1; phase_next = PH_SECOND;
            end
            PH_SECOND: begin
              scl_reg_next = 1'b1; phase_next = PH_THIRD;
            end
            PH_THIRD: begin
              if (!tick.sda_in) begin
                scl_reg_next = 1'b0; phase_next = PH_FOURTH;
              end else if (timeout_counter_next <= TMO_W'(1)) begin
                // timeout: flag failure and fall into the stop sequence
                timeout_counter_next = '0;
                fail_reg_next        = 1'b1;
                scl_reg_next = 1'b0; sda_reg_next = 1'b0; release_reg_next = 1'b0;
                active_command_next  = K_STOP;
                phase_next           = PH_SECOND;
              end else begin
                timeout_counter_next = timeout_counter_next - TMO_W'(1);
              end
            end
            default: begin
              release_reg_next = 1'b0;
              busy_reg_next = 1'b0; done_next = 1'b1;
              phase_next = PH_FIRST; bit_counter_next = '0;
            end
          endcase
        end
        K_RECV: begin
          if (phase_next == PH_FIRST) begin
            if (bit_counter_next >= CNT_W'(BYTE_BITS)) begin
              release_reg_next = 1'b0;
              busy_reg_next = 1'b0; done_next = 1'b1;
              phase_next = PH_FIRST; bit_counter_next = '0;
            end else begin
              release_reg_next    = 1'b1;
              shift_register_next = {shift_register_next[BYTE_BITS-2:0], 1'b0};
              scl_reg_next        = 1'b1;
              phase_next          = PH_SECOND;
            end
          end else begin
            shift_register_next[0] = shift_register_next[0] | tick.sda_in;
            scl_reg_next     = 1'b0;
            bit_counter_next = bit_counter_next + CNT_W'(1);
            phase_next       = PH_FIRST;
          end
        end
        K_ACK, K_NACK: begin
          case (phase_next)
            PH_FIRST: begin
              sda_reg_next     = (active_command_next == K_ACK) ? 1'b0 : 1'b1;
              release_reg_next = 1'b0;
              phase_next       = PH_SECOND;
            end
            PH_SECOND: begin
              scl_reg_next = 1'b1; phase_next = PH_THIRD;
            end
            PH_THIRD: begin
              scl_reg_next = 1'b0; phase_next = PH_FOURTH;
            end
            default: begin
              if (active_command_next == K_ACK) sda_reg_next = 1'b1;
              busy_reg_next = 1'b0; done_next = 1'b1;
              phase_next = PH_FIRST; bit_counter_next = '0;
            end
          endcase
        end
        default: begin
          // bus reset: clock scl until sda reads high or the pulse limit is hit
          case (phase_next)
            PH_FIRST: begin
              release_reg_next = 1'b1; scl_reg_next = 1'b1; phase_next = PH_SECOND;
            end
            PH_SECOND: begin
              scl_reg_next     = 1'b0;
              bit_counter_next = bit_counter_next + CNT_W'(1);
              phase_next       = PH_THIRD;
            end
            default: begin
              if (tick.sda_in || bit_counter_next >= lim) begin
                busy_reg_next = 1'b0; done_next = 1'b1;
                phase_next = PH_FIRST; bit_counter_next = '0;
              end else begin
                scl_reg_next = 1'b1; phase_next = PH_SECOND;
              end
            end
          endcase
        end
      endcase
    end

    result_new.scl_level    = scl_reg_next;
    result_new.sda_level    = sda_reg_next;
    result_new.sda_released = release_reg_next;
    result_new.busy_res     = busy_reg_next;
    result_new.done_res     = done_next;
    result_new.rx_data      = shift_register_next;
    result_new.ack_failed   = fail_reg_next;
  end

  // state advances only on an accepted tick transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      active_command  <= K_START;
      phase           <= PH_FIRST;
      bit_counter     <= '0;
      shift_register  <= '0;
      timeout_counter <= '0;
      scl_reg         <= 1'b1;
      sda_reg         <= 1'b1;
      release_reg     <= 1'b0;
      busy_reg        <= 1'b0;
      fail_reg        <= 1'b0;
    end else if (accept) begin
      active_command  <= active_command_next;
      phase           <= phase_next;
      bit_counter     <= bit_counter_next;
      shift_register  <= shift_register_next;
      timeout_counter <= timeout_counter_next;
      scl_reg         <= scl_reg_next;
      sda_reg         <= sda_reg_next;
      release_reg     <= release_reg_next;
      busy_reg        <= busy_reg_next;
      fail_reg        <= fail_reg_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) out_data <= skid_data;
      else if (accept) out_data <= result_new;
    end else if (accept) begin
      skid_data <= result_new;
    end
  end

  assign pins.valid        = out_valid;
  assign pins.scl_level    = out_data.scl_level;
  assign pins.sda_level    = out_data.sda_level;
  assign pins.sda_released = out_data.sda_released;
  assign pins.busy_res     = out_data.busy_res;
  assign pins.done_res     = out_data.done_res;
  assign pins.rx_data      = out_data.rx_data;
  assign pins.ack_failed   = out_data.ack_failed;

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the i2c master bit sequencer: tick stimulus, pin prediction, checks
module tb_top;
  import i2cms_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int LIMIT_CYCLES  = 600000;
  localparam int RANDOM_TICKS  = 300;
  localparam int TAIL_CYCLES   = 10;
  localparam int PRINT_LIMIT   = 50;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  i2cms_in_if  tick_ch ();
  i2cms_out_if pin_ch ();

  i2c_master_bit_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .pins      (pin_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // pin snapshots predicted for accepted ticks, oldest first
  result_t expected_pins[$];
  result_t oldest_pins;
  int      error_count  = 0;
  int      result_idx   = 0;
  int      tick_count   = 0;

  // idling controls shared by the sender, the receiver and the tests
  bit src_no_gap  = 1'b0;
  bit sink_no_gap = 1'b0;
  int hold_req    = 0;

  // predicted sequencer state and configuration
  kind_t      cmd_q;
  phase_t     ph_q;
  logic [3:0] bcnt_q;
  logic [7:0] shreg_q;
  logic [2:0] tmo_q;
  logic       scl_q, sda_q, rel_q, busy_q, fail_q, done_q;
  logic [2:0] ack_to_q;
  logic [3:0] rcc_q;

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic rand_sda(int low_pct);
    return chance(low_pct) ? 1'b0 : 1'b1;
  endfunction

  // mostly short stalls, now and then a long one
  function automatic int pick_stall();
    return chance(85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic void end_command();
    busy_q = 1'b0;
    done_q = 1'b1;
    ph_q   = PH_FIRST;
    bcnt_q = '0;
  endfunction

  // first step of a stop: both lines low, sda driven
  function automatic void begin_stop();
    scl_q = 1'b0;
    sda_q = 1'b0;
    rel_q = 1'b0;
  endfunction

  // one quarter-bit tick of the sequencer; returns the pin snapshot after the update
  function automatic result_t step_sequencer(logic cv, logic [2:0] k, logic [7:0] tx,
                                             logic sdi);
    result_t    r;
    logic [3:0] lim;
    done_q = 1'b0;
    // a command only lands while idle
    if (!busy_q && cv) begin
      cmd_q  = kind_t'(k);
      ph_q   = PH_FIRST;
      bcnt_q = '0;
      busy_q = 1'b1;
      case (cmd_q)
        K_SEND: shreg_q = tx;
        K_RECV: shreg_q = '0;
        K_WAIT_ACK: begin
          tmo_q  = (ack_to_q != 0) ? ack_to_q : 3'd1;
          fail_q = 1'b0;
        end
        default: ;
      endcase
    end
    if (busy_q) begin
      case (cmd_q)
        K_START: begin
          case (ph_q)
            PH_FIRST: begin
              sda_q = 1'b1;
              scl_q = 1'b1;
              rel_q = 1'b0;
              ph_q  = PH_SECOND;
            end
            PH_SECOND: begin
              sda_q = 1'b0;
              ph_q  = PH_THIRD;
            end
            default: begin
              scl_q = 1'b0;
              end_command();
            end
          endcase
        end
        K_STOP: begin
          case (ph_q)
            PH_FIRST: begin
              begin_stop();
              ph_q = PH_SECOND;
            end
            PH_SECOND: begin
              scl_q = 1'b1;
              ph_q  = PH_THIRD;
            end
            default: begin
              sda_q = 1'b1;
              end_command();
            end
          endcase
        end
        K_SEND: begin
          case (ph_q)
            PH_FIRST: begin
              if (bcnt_q >= BYTE_BITS) begin
                end_command();
              end else begin
                scl_q = 1'b0;
                rel_q = 1'b0;
                ph_q  = PH_SECOND;
              end
            end
            PH_SECOND: begin
              sda_q   = shreg_q[7];
              shreg_q = shreg_q << 1;
              ph_q    = PH_THIRD;
            end
            PH_THIRD: begin
              scl_q  = 1'b1;
              bcnt_q = bcnt_q + 4'd1;
              ph_q   = (bcnt_q >= BYTE_BITS) ? PH_FOURTH : PH_FIRST;
            end
            default: begin
              scl_q = 1'b0;
              ph_q  = PH_FIRST;
            end
          endcase
        end
        K_WAIT_ACK: begin
          case (ph_q)
            PH_FIRST: begin
              rel_q = 1'b1;
              ph_q  = PH_SECOND;
            end
            PH_SECOND: begin
              scl_q = 1'b1;
              ph_q  = PH_THIRD;
            end
            PH_THIRD: begin
              if (!sdi) begin
                scl_q = 1'b0;
                ph_q  = PH_FOURTH;
              end else if (tmo_q <= 3'd1) begin
                // timeout: flag it and fall straight into a stop
                tmo_q  = '0;
                fail_q = 1'b1;
                begin_stop();
                cmd_q  = K_STOP;
                ph_q   = PH_SECOND;
              end else begin
                tmo_q = tmo_q - 3'd1;
              end
            end
            default: begin
              rel_q = 1'b0;
              end_command();
            end
          endcase
        end
        K_RECV: begin
          if (ph_q == PH_FIRST) begin
            if (bcnt_q >= BYTE_BITS) begin
              rel_q = 1'b0;
              end_command();
            end else begin
              rel_q   = 1'b1;
              shreg_q = shreg_q << 1;
              scl_q   = 1'b1;
              ph_q    = PH_SECOND;
            end
          end else begin
            shreg_q = shreg_q | {7'd0, sdi};
            scl_q   = 1'b0;
            bcnt_q  = bcnt_q + 4'd1;
            ph_q    = PH_FIRST;
          end
        end
        K_ACK, K_NACK: begin
          case (ph_q)
            PH_FIRST: begin
              sda_q = (cmd_q == K_ACK) ? 1'b0 : 1'b1;
              rel_q = 1'b0;
              ph_q  = PH_SECOND;
            end
            PH_SECOND: begin
              scl_q = 1'b1;
              ph_q  = PH_THIRD;
            end
            PH_THIRD: begin
              scl_q = 1'b0;
              ph_q  = PH_FOURTH;
            end
            default: begin
              if (cmd_q == K_ACK) sda_q = 1'b1;
              end_command();
            end
          endcase
        end
        default: begin
          // bus reset: pulse scl until sda reads high or the pulse limit is hit
          lim = (rcc_q != 0) ? rcc_q : 4'd1;
          case (ph_q)
            PH_FIRST: begin
              rel_q = 1'b1;
              scl_q = 1'b1;
              ph_q  = PH_SECOND;
            end
            PH_SECOND: begin
              scl_q  = 1'b0;
              bcnt_q = bcnt_q + 4'd1;
              ph_q   = PH_THIRD;
            end
            default: begin
              if (sdi || bcnt_q >= lim) begin
                end_command();
              end else begin
                scl_q = 1'b1;
                ph_q  = PH_SECOND;
              end
            end
          endcase
        end
      endcase
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.sda_released = rel_q;
    r.busy_res     = busy_q;
    r.done_res     = done_q;
    r.rx_data      = shreg_q;
    r.ack_failed   = fail_q;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < PRINT_LIMIT) $display("mismatch at result %0d: %s", result_idx, what);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // offer one tick; valid stays high on return so back-to-back ticks need no extra edge
  task automatic send_tick(logic cv, logic [2:0] k, logic [7:0] tx, logic sdi);
    int gap;
    gap = (src_no_gap || chance(55)) ? 0 : pick_stall();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.cmd_valid <= cv;
    tick_ch.kind      <= k;
    tick_ch.tx_byte   <= tx;
    tick_ch.sda_in    <= sdi;
    do @(posedge clk); while (!tick_ch.ready);
    // transaction taken at this edge: predict its pin snapshot
    expected_pins.push_back(step_sequencer(cv, k, tx, sdi));
    tick_count++;
  endtask

  // issue a command and keep ticking until it completes; noise ticks carry commands
  // that the sequencer must ignore while busy
  task automatic do_command(kind_t k, logic [7:0] tx, int low_pct, int noise_pct);
    if (chance(15)) begin
      repeat ($urandom_range(1, 3)) send_tick(1'b0, 3'($urandom), 8'($urandom), rand_sda(50));
    end
    send_tick(1'b1, k, tx, rand_sda(low_pct));
    while (busy_q) begin
      send_tick(chance(noise_pct), 3'($urandom_range(0, 7)), 8'($urandom), rand_sda(low_pct));
    end
  endtask

  task automatic settle_sequencer();
    while (busy_q) send_tick(1'b0, 3'($urandom), 8'($urandom), rand_sda(50));
  endtask

  // sender goes quiet until every predicted snapshot has been checked
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  // both registers are written, only with the sequencer idle and nothing in flight
  task automatic set_config(logic [CFG_W-1:0] ack, logic [CFG_W-1:0] rcc);
    settle_sequencer();
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_data  <= ack;
    @(posedge clk);
    ack_to_q = ack[2:0];
    cfg_index <= CFG_RESET_CLOCK_COUNT;
    cfg_data  <= rcc;
    @(posedge clk);
    rcc_q = rcc;
    cfg_we <= 1'b0;
  endtask

  // every command at least once at the reset configuration, plus the byte extremes
  task automatic test_directed_commands();
    do_command(K_START, 8'h00, 50, 0);
    do_command(K_SEND, 8'hFF, 50, 0);
    do_command(K_WAIT_ACK, 8'h00, 100, 0);
    do_command(K_RECV, 8'h00, 50, 0);
    do_command(K_ACK, 8'h00, 50, 0);
    do_command(K_RECV, 8'h00, 0, 0);
    do_command(K_NACK, 8'h00, 50, 0);
    do_command(K_SEND, 8'h00, 50, 0);
    // sda never pulled low: ack wait times out into a stop
    do_command(K_WAIT_ACK, 8'h00, 0, 0);
    do_command(K_BUS_RESET, 8'h00, 100, 0);
    do_command(K_BUS_RESET, 8'h00, 0, 0);
    do_command(K_STOP, 8'h00, 50, 0);
  endtask

  // every tick of the command carries another command, all of them ignored
  task automatic test_busy_commands();
    do_command(K_START, 8'h5A, 50, 100);
    do_command(K_SEND, 8'hA5, 50, 100);
    do_command(K_WAIT_ACK, 8'h00, 30, 100);
    do_command(K_STOP, 8'h00, 50, 100);
  endtask

  // zero timeout and pulse count act as one; the top values run longest
  task automatic test_config_extremes();
    logic [CFG_W-1:0] ack_vals[5] = '{4'd0, 4'd1, 4'd7, 4'd12, 4'd3};
    logic [CFG_W-1:0] rcc_vals[5] = '{4'd0, 4'd1, 4'd15, 4'd5, 4'd9};
    for (int i = 0; i < 5; i++) begin
      set_config(ack_vals[i], rcc_vals[i]);
      do_command(K_WAIT_ACK, 8'h00, 0, 0);
      do_command(K_WAIT_ACK, 8'h00, 20, 10);
      do_command(K_BUS_RESET, 8'h00, 100, 0);
      do_command(K_BUS_RESET, 8'h00, 70, 10);
    end
  endtask

  // receiver holds off long while ticks keep coming, so the input side stalls
  task automatic test_backpressure();
    hold_req = 60;
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (hold_req != 0);
    src_no_gap = 1'b1;
    repeat (40) send_tick(chance(30), 3'($urandom), 8'($urandom), rand_sda(50));
    src_no_gap = 1'b0;
    // sender pauses until everything has come back
    drain_results();
    sink_no_gap = 1'b1;
    src_no_gap  = 1'b1;
    do_command(K_START, 8'h00, 50, 0);
    do_command(K_SEND, 8'($urandom), 50, 0);
    sink_no_gap = 1'b0;
    src_no_gap  = 1'b0;
    settle_sequencer();
    drain_results();
  endtask

  // well-formed frame: optional bus reset, start, address, ack, data bytes read or written, stop
  task automatic run_frame();
    logic [7:0] addr;
    int         nbytes;
    addr   = 8'($urandom);
    nbytes = $urandom_range(1, 3);
    if (chance(15)) do_command(K_BUS_RESET, 8'h00, 70, 5);
    do_command(K_START, 8'h00, 50, 10);
    do_command(K_SEND, addr, 50, 10);
    do_command(K_WAIT_ACK, 8'h00, 40, 10);
    // a timed-out ack wait has already put a stop on the bus
    if (fail_q) return;
    for (int i = 0; i < nbytes; i++) begin
      if (addr[0]) begin
        do_command(K_RECV, 8'h00, 50, 10);
        do_command((i == nbytes - 1) ? K_NACK : K_ACK, 8'h00, 50, 10);
      end else begin
        do_command(K_SEND, 8'($urandom), 50, 10);
        do_command(K_WAIT_ACK, 8'h00, 40, 10);
        if (fail_q) return;
      end
    end
    do_command(K_STOP, 8'h00, 50, 10);
  endtask

  task automatic test_random_bus_traffic();
    int  start_ticks;
    int  frames;
    bit  steady;
    start_ticks = tick_count;
    frames      = 0;
    while (tick_count - start_ticks < RANDOM_TICKS) begin
      if (frames % 5 == 4) begin
        set_config(chance(25) ? (chance(50) ? 4'd0 : 4'd7) : 4'($urandom),
                   chance(25) ? (chance(50) ? 4'd1 : 4'd15) : 4'($urandom));
      end
      steady      = chance(20);
      src_no_gap  = steady;
      sink_no_gap = steady;
      if (chance(80)) begin
        run_frame();
      end else begin
        // broken frame: commands in any order, lots of ignored noise
        repeat ($urandom_range(2, 6)) begin
          do_command(kind_t'($urandom_range(0, 7)), 8'($urandom), 50, 40);
        end
      end
      frames++;
    end
    src_no_gap  = 1'b0;
    sink_no_gap = 1'b0;
    settle_sequencer();
  endtask

  // receiver: ready runs and stalls of random length, or a requested long hold-off
  initial begin : sink_side
    int   span;
    logic lvl;
    pin_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        lvl      = 1'b0;
        span     = hold_req;
        hold_req = 0;
      end else if (sink_no_gap) begin
        lvl  = 1'b1;
        span = 1;
      end else if (chance(65)) begin
        lvl  = 1'b1;
        span = $urandom_range(1, 8);
      end else begin
        lvl  = 1'b0;
        span = pick_stall();
      end
      pin_ch.ready <= lvl;
      repeat (span) @(posedge clk);
    end
  end

  // each pin transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pin_ch.valid && pin_ch.ready) begin
      if (expected_pins.size() == 0) begin
        report_mismatch("pin snapshot with nothing expected");
      end else begin
        oldest_pins = expected_pins.pop_front();
        check_field("scl_level", 8'(oldest_pins.scl_level), 8'(pin_ch.scl_level));
        check_field("sda_level", 8'(oldest_pins.sda_level), 8'(pin_ch.sda_level));
        check_field("sda_released", 8'(oldest_pins.sda_released), 8'(pin_ch.sda_released));
        check_field("busy_res", 8'(oldest_pins.busy_res), 8'(pin_ch.busy_res));
        check_field("done_res", 8'(oldest_pins.done_res), 8'(pin_ch.done_res));
        check_field("rx_data", oldest_pins.rx_data, pin_ch.rx_data);
        check_field("ack_failed", 8'(oldest_pins.ack_failed), 8'(pin_ch.ack_failed));
      end
      result_idx++;
    end
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_ACK_TIMEOUT;
    cfg_data          <= '0;
    tick_ch.valid     <= 1'b0;
    tick_ch.cmd_valid <= 1'b0;
    tick_ch.kind      <= K_START;
    tick_ch.tx_byte   <= '0;
    tick_ch.sda_in    <= 1'b1;
    // predictor at its reset state: bus idle high, sda driven
    cmd_q    = K_START;
    ph_q     = PH_FIRST;
    bcnt_q   = '0;
    shreg_q  = '0;
    tmo_q    = '0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
    rel_q    = 1'b0;
    busy_q   = 1'b0;
    fail_q   = 1'b0;
    done_q   = 1'b0;
    ack_to_q = ACK_TIMEOUT_RST;
    rcc_q    = RESET_CLOCK_COUNT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_commands();
    test_busy_commands();
    test_config_extremes();
    test_backpressure();
    test_random_bus_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pins.size() != 0) begin
      report_mismatch($sformatf("%0d pin snapshots never arrived", expected_pins.size()));
    end
    if (error_count == 0) begin
      $display("i2c_master_bit_sequencer verification clean");
    end else begin
      $display("i2c_master_bit_sequencer verification failed");
    end
    $finish;
  end

  // hung handshake guard
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("i2c_master_bit_sequencer verification failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_if.sv
hdl/i2c_master_bit_sequencer.sv
dv/tb_top.sv
